// ===== design/euler_rotation_derivative_macros.svh =====
// ----------------------------------------------------------------------------
// euler rotation derivative assertion macros
// shared assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATION_DERIVATIVE_MACROS_SVH
`define EULER_ROTATION_DERIVATIVE_MACROS_SVH
`ifndef SYNTHESIS
`define ERD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ERD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ERD_ASSERT(label, clk, rst_n, prop, msg)
`define ERD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/erd_pkg.sv =====
// ----------------------------------------------------------------------------
// erd_pkg
// types, constants and helpers for the euler rotation derivative block
// ----------------------------------------------------------------------------
package erd_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int CORDIC_STEPS    = 24;
    localparam int ZFRAC           = 20;
    // datapath widths: x/y Q30 plus headroom, z in degrees * 2^20
    localparam int XW = 33;
    localparam int ZW = 30;
    localparam int AW = 16;
    // cordic iterations per pipeline stage
    localparam int STEPS_PER_STAGE = 4;
    localparam int CSTAGES = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int SIDX_W  = $clog2(CSTAGES);

    localparam logic signed [XW-1:0] ONE_Q30  = XW'(64'sd1 << 30);
    localparam logic signed [XW-1:0] NONE_Q30 = -ONE_Q30;
    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
    localparam logic signed [17:0] FULL_A    = 18'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [17:0] HALF_A    = 18'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [17:0] QUARTER_A = 18'(90 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic signed [AW-1:0] angle_first;
        logic signed [AW-1:0] angle_second;
        logic signed [AW-1:0] angle_third;
    } erd_in_t;

    typedef struct packed {
        logic signed [15:0] entry_11;
        logic signed [15:0] entry_12;
        logic signed [15:0] entry_13;
        logic signed [15:0] entry_21;
        logic signed [15:0] entry_22;
        logic signed [15:0] entry_23;
        logic signed [15:0] entry_31;
        logic signed [15:0] entry_32;
        logic signed [15:0] entry_33;
    } erd_out_t;

    // one cordic lane state
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } erd_cord_t;

    // sine and cosine of one angle, Q30
    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } erd_sc_t;

    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        case (i)
            0: atan_deg = ZW'(47185920);
            1: atan_deg = ZW'(27855475);
            2: atan_deg = ZW'(14718068);
            3: atan_deg = ZW'(7471121);
            4: atan_deg = ZW'(3750058);
            5: atan_deg = ZW'(1876857);
            6: atan_deg = ZW'(938658);
            7: atan_deg = ZW'(469357);
            8: atan_deg = ZW'(234682);
            9: atan_deg = ZW'(117342);
            10: atan_deg = ZW'(58671);
            11: atan_deg = ZW'(29335);
            12: atan_deg = ZW'(14668);
            13: atan_deg = ZW'(7334);
            14: atan_deg = ZW'(3667);
            15: atan_deg = ZW'(1833);
            16: atan_deg = ZW'(917);
            17: atan_deg = ZW'(458);
            18: atan_deg = ZW'(229);
            19: atan_deg = ZW'(115);
            20: atan_deg = ZW'(57);
            21: atan_deg = ZW'(29);
            22: atan_deg = ZW'(14);
            23: atan_deg = ZW'(7);
            default: atan_deg = '0;
        endcase
    endfunction

    // q30 product, rounded half up; |a|,|b| <= 2^30
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = a * b + (64'sd1 <<< 29);
            qmul = 32'(p >>> 30);
        end
    endfunction

    // q30 to output format with rounding and saturation
    function automatic logic signed [15:0] to_out(input logic signed [31:0] q);
        logic signed [32:0] v;
        logic signed [32:0] lim;
        begin
            lim = 33'sd1 <<< OUT_FRAC_BITS;
            v   = (33'(q) + (33'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            if (v > 33'sd32767) v = 33'sd32767;
            if (v < -33'sd32768) v = -33'sd32768;
            to_out = v[15:0];
        end
    endfunction

endpackage

// ===== design/erd_sincos.sv =====
// ----------------------------------------------------------------------------
// erd_sincos
// pipelined sine/cosine: angle reduction stage, then cordic stages of
// four iterations each, then a saturate and sign stage
// ----------------------------------------------------------------------------
module erd_sincos
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [erd_pkg::AW-1:0]  angle,
    output erd_pkg::erd_sc_t               sc
);
    import erd_pkg::*;

    logic signed [17:0] r_next;
    logic               neg_next;
    erd_cord_t          red_reg;
    erd_cord_t          st_reg [CSTAGES];
    erd_cord_t          st_next [CSTAGES];
    erd_sc_t            sc_reg;
    erd_sc_t            sc_next;

    // reduce into (-180,180], fold into [-90,90]
    always_comb
    begin
        logic signed [17:0] a;
        logic signed [17:0] r;
        a = 18'(angle);
        r = a;
        if (r > HALF_A + FULL_A) r = r - FULL_A - FULL_A;
        else if (r > HALF_A) r = r - FULL_A;
        if (r <= -HALF_A - FULL_A) r = r + FULL_A + FULL_A;
        else if (r <= -HALF_A) r = r + FULL_A;
        neg_next = 1'b0;
        if (r > QUARTER_A)
        begin
            r = r - HALF_A;
            neg_next = 1'b1;
        end
        else if (r < -QUARTER_A)
        begin
            r = r + HALF_A;
            neg_next = 1'b1;
        end
        r_next = r;
    end

    // reduction stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg.x   <= GAIN_Q30;
            red_reg.y   <= '0;
            red_reg.z   <= ZW'(r_next) <<< (ZFRAC - ANGLE_FRAC_BITS);
            red_reg.neg <= neg_next;
        end
    end

    // cordic stages
    for (genvar g = 0; g < CSTAGES; g++)
    begin : g_stage
        always_comb
        begin
            erd_cord_t v;
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            v = (g == 0) ? red_reg : st_reg[(g == 0) ? 0 : g - 1];
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                xs = v.x >>> (g * STEPS_PER_STAGE + k);
                ys = v.y >>> (g * STEPS_PER_STAGE + k);
                if (!v.z[ZW-1])
                begin
                    v.x = v.x - ys;
                    v.y = v.y + xs;
                    v.z = v.z - atan_deg(g * STEPS_PER_STAGE + k);
                end
                else
                begin
                    v.x = v.x + ys;
                    v.y = v.y - xs;
                    v.z = v.z + atan_deg(g * STEPS_PER_STAGE + k);
                end
            end
            st_next[g] = v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    // saturate and apply the fold sign
    always_comb
    begin
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        x = st_reg[CSTAGES-1].x;
        y = st_reg[CSTAGES-1].y;
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < NONE_Q30) x = NONE_Q30;
        if (y > ONE_Q30) y = ONE_Q30;
        if (y < NONE_Q30) y = NONE_Q30;
        if (st_reg[CSTAGES-1].neg)
        begin
            x = -x;
            y = -y;
        end
        sc_next.s = 32'(y);
        sc_next.c = 32'(x);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

// ===== design/euler_rotation_derivative.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_derivative
// dR/dPhi of a Z-X-Z euler rotation matrix from three fixed-point angles
// ----------------------------------------------------------------------------
// channel  direction  payload    handshake
// in       input      erd_in_t   in_valid / in_ready
// out      output     erd_out_t  out_valid / out_ready
//
// one triple per cycle while the output is not stalled, through eleven register stages
// (reduction, six cordic stages of four iterations, sign, two product stages,
// rounding); reset clears only the stage valid bits.
// a stalled output freezes the whole pipeline, and in_ready stays low until
// the output transfer is taken, even when earlier stages hold bubbles.
// ----------------------------------------------------------------------------
`include "euler_rotation_derivative_macros.svh"

module euler_rotation_derivative
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  erd_pkg::erd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output erd_pkg::erd_out_t out_data
);
    import erd_pkg::*;

    localparam int SC_LAT = CSTAGES + 2;
    localparam int LAT    = SC_LAT + 3;

    logic       en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    erd_sc_t    sc1;
    erd_sc_t    sc2;
    erd_sc_t    sc3;

    // pipeline moves when the last stage is empty or being taken
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    erd_sincos u_sc1 (.clk(clk), .en(en), .angle(in_data.angle_first),  .sc(sc1));
    erd_sincos u_sc2 (.clk(clk), .en(en), .angle(in_data.angle_second), .sc(sc2));
    erd_sincos u_sc3 (.clk(clk), .en(en), .angle(in_data.angle_third),  .sc(sc3));

    // first products
    logic signed [31:0] p21_reg, pn12_reg, p23_reg, p22_reg, p23c_reg;
    logic signed [31:0] p31_reg, p32_reg, n2_reg;
    logic signed [31:0] s1_reg, s3_reg, c3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p21_reg  <= qmul(sc2.s, sc1.s);
            pn12_reg <= qmul(-sc1.c, sc2.s);
            p23_reg  <= qmul(sc2.s, sc3.c);
            p22_reg  <= qmul(sc2.c, sc3.s);
            p23c_reg <= qmul(sc2.c, sc3.c);
            p31_reg  <= qmul(sc1.s, sc2.c);
            p32_reg  <= qmul(-sc1.c, sc2.c);
            n2_reg   <= -sc2.s;
            s1_reg   <= sc1.s;
            s3_reg   <= sc3.s;
            c3_reg   <= sc3.c;
        end
    end

    // second products
    logic signed [31:0] q11_reg, q12_reg, q13_reg, q21_reg, q22_reg, q23_reg;
    logic signed [31:0] q31_reg, q32_reg, q33_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q11_reg <= qmul(p21_reg, s3_reg);
            q12_reg <= qmul(pn12_reg, s3_reg);
            q13_reg <= p22_reg;
            q21_reg <= qmul(p23_reg, s1_reg);
            q22_reg <= qmul(pn12_reg, c3_reg);
            q23_reg <= p23c_reg;
            q31_reg <= p31_reg;
            q32_reg <= p32_reg;
            q33_reg <= n2_reg;
        end
    end

    // rounding to output format
    erd_out_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.entry_11 <= to_out(q11_reg);
            out_reg.entry_12 <= to_out(q12_reg);
            out_reg.entry_13 <= to_out(q13_reg);
            out_reg.entry_21 <= to_out(q21_reg);
            out_reg.entry_22 <= to_out(q22_reg);
            out_reg.entry_23 <= to_out(q23_reg);
            out_reg.entry_31 <= to_out(q31_reg);
            out_reg.entry_32 <= to_out(q32_reg);
            out_reg.entry_33 <= to_out(q33_reg);
        end
    end

    assign out_data = out_reg;

    `ERD_ASSERT(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output changed")
    `ERD_ASSERT(a_ready_when_free, clk, rst_n, !out_valid |-> in_ready, "not ready with empty output")
    `ERD_ASSERT(a_entry_range, clk, rst_n, out_valid |-> out_data.entry_33 <= 16'sd16384 && out_data.entry_33 >= -16'sd16384, "entry out of range")
    `ERD_ASSERT(a_latency, clk, rst_n, in_ready && !in_valid |=> !vld_reg[0], "bubble became valid")

endmodule

// ===== sim/euler_rotation_derivative_checker.sv =====
// ----------------------------------------------------------------------------
// euler rotation derivative checker
// watches both channels, predicts dR/dPhi for every input transfer and
// compares each output transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module euler_rotation_derivative_checker
    import erd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  erd_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  erd_out_t out_data,
    output int       fail_count,
    output int       pending
);

    localparam int TURN_CODE = 360 * 64;
    localparam int HALF_CODE = 180 * 64;
    localparam int QUAD_CODE = 90 * 64;

    localparam longint ARCTAN_DEG [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    erd_out_t matrix_queue[$];

    // arithmetic shift, floor toward minus infinity
    function automatic longint shr_floor(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q30_product(longint a, longint b);
        return shr_floor(a * b + (64'sd1 <<< 29), 30);
    endfunction

    // sine and cosine in q30 via 24-step rotation
    function automatic void angle_sincos(logic signed [15:0] raw,
                                         output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        flip = 0;
        r = longint'(raw) % TURN_CODE;
        if (r < 0) r += TURN_CODE;
        if (r > HALF_CODE) r -= TURN_CODE;
        if (r > QUAD_CODE) begin r -= HALF_CODE; flip = 1; end
        else if (r < -QUAD_CODE) begin r += HALF_CODE; flip = 1; end
        z = r <<< 14;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (z >= 0) begin x -= ys; y += xs; z -= ARCTAN_DEG[i]; end
            else        begin x += ys; y -= xs; z += ARCTAN_DEG[i]; end
        end
        x = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        y = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        if (flip) begin x = -x; y = -y; end
        s = y;
        c = x;
    endfunction

    function automatic logic signed [15:0] q30_to_entry(longint q);
        longint lim;
        longint v;
        lim = 64'sd1 <<< OUT_FRAC_BITS;
        v = shr_floor(q + (64'sd1 <<< (29 - OUT_FRAC_BITS)), 30 - OUT_FRAC_BITS);
        v = clip(v, -lim, lim);
        v = clip(v, -32768, 32767);
        return v[15:0];
    endfunction

    function automatic erd_out_t derivative_matrix(erd_in_t a);
        longint s1, c1, s2, c2, s3, c3;
        erd_out_t m;
        angle_sincos(a.angle_first, s1, c1);
        angle_sincos(a.angle_second, s2, c2);
        angle_sincos(a.angle_third, s3, c3);
        m.entry_11 = q30_to_entry(q30_product(q30_product(s2, s1), s3));
        m.entry_12 = q30_to_entry(q30_product(q30_product(-c1, s2), s3));
        m.entry_13 = q30_to_entry(q30_product(c2, s3));
        m.entry_21 = q30_to_entry(q30_product(q30_product(s2, c3), s1));
        m.entry_22 = q30_to_entry(q30_product(q30_product(-c1, s2), c3));
        m.entry_23 = q30_to_entry(q30_product(c2, c3));
        m.entry_31 = q30_to_entry(q30_product(s1, c2));
        m.entry_32 = q30_to_entry(q30_product(-c1, c2));
        m.entry_33 = q30_to_entry(-s2);
        return m;
    endfunction

    task automatic check_entry(string name, logic signed [15:0] exp_v,
                               logic signed [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
    initial pending = 0;

    // predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        erd_out_t e;
        if (rst_n && in_valid && in_ready)
            matrix_queue.push_back(derivative_matrix(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (matrix_queue.size() == 0)
            begin
                $error("output transfer with no prediction waiting");
                fail_count++;
            end
            else
            begin
                e = matrix_queue.pop_front();
                check_entry("entry_11", e.entry_11, out_data.entry_11);
                check_entry("entry_12", e.entry_12, out_data.entry_12);
                check_entry("entry_13", e.entry_13, out_data.entry_13);
                check_entry("entry_21", e.entry_21, out_data.entry_21);
                check_entry("entry_22", e.entry_22, out_data.entry_22);
                check_entry("entry_23", e.entry_23, out_data.entry_23);
                check_entry("entry_31", e.entry_31, out_data.entry_31);
                check_entry("entry_32", e.entry_32, out_data.entry_32);
                check_entry("entry_33", e.entry_33, out_data.entry_33);
            end
        end
        pending = matrix_queue.size();
    end

endmodule

// ===== sim/euler_rotation_derivative_tb.sv =====
// ----------------------------------------------------------------------------
// euler rotation derivative testbench
// directed corner angles then random triples with random idle bursts on
// both channels but the calm tail; a side checker predicts and compares every matrix
// ----------------------------------------------------------------------------
module euler_rotation_derivative_tb;
    import erd_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_ITEMS   = 150;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    erd_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    erd_out_t out_data;
    int       fail_count;
    int       pending;
    bit       calm;

    euler_rotation_derivative dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    euler_rotation_derivative_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // one transfer on the input channel, optional idle burst first
    task automatic send_angles(logic signed [15:0] a1, logic signed [15:0] a2,
                               logic signed [15:0] a3);
        if (!calm && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{angle_first: a1, angle_second: a2, angle_third: a3};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 8)) * 2880 - 11520);
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    // output side back-pressure in bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic signed [15:0] corners [12];
        int wait_count;
        corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
                    16'sd5760, -16'sd5760, 16'sd32767, -16'sd32768, 16'sd1,
                    -16'sd1, 16'sd17280};
        calm     = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners: each corner in each position
        foreach (corners[i])
            send_angles(corners[i], corners[(i + 5) % 12], corners[(i + 9) % 12]);
        send_angles(16'sd11520, 16'sd11520, 16'sd11520);
        send_angles(16'sd5760, 16'sd5760, 16'sd5760);
        send_angles(-16'sd1, -16'sd1, -16'sd1);

        // drain fully before the random part
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1;
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        in_valid <= 1'b0;

        wait_count = 0;
        while (pending != 0 && wait_count < 20000)
        begin
            @(negedge clk);
            wait_count++;
        end
        repeat (30) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
